FILE: rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// Assembly source tokenizer package
// Token kinds, character codes, scan modes and the token record shared by
// the scanner, the output queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ast_pkg;

	localparam int LINE_W   = 16;
	localparam int COLUMN_W = 16;
	localparam int OFFSET_W = 32;
	localparam int LENGTH_W = 16;

	localparam logic [3:0] K_NUMBER   = 4'd0;
	localparam logic [3:0] K_IDENT    = 4'd1;
	localparam logic [3:0] K_NEWLINE  = 4'd2;
	localparam logic [3:0] K_COMMA    = 4'd3;
	localparam logic [3:0] K_COLON    = 4'd4;
	localparam logic [3:0] K_LBRACKET = 4'd5;
	localparam logic [3:0] K_RBRACKET = 4'd6;
	localparam logic [3:0] K_PLUS     = 4'd7;
	localparam logic [3:0] K_MINUS    = 4'd8;
	localparam logic [3:0] K_UNKNOWN  = 4'd9;
	localparam logic [3:0] K_EOF      = 4'd10;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_NUMBER  = 4'b0010,
		MODE_IDENT   = 4'b0100,
		MODE_COMMENT = 4'b1000
	} scan_mode_t;

	typedef struct packed {
		logic [3:0]          kind;
		logic [LINE_W-1:0]   line;
		logic [COLUMN_W-1:0] column;
		logic [OFFSET_W-1:0] offset;
		logic [LENGTH_W-1:0] length;
		logic [7:0]          first;
		logic                last;
	} token_t;

	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

endpackage

`default_nettype wire

FILE: rtl/ast_scan.sv
// ----------------------------------------------------------------------------
// Tokenizer scan stage
// Holds the position counters and word state, classifies one byte per cycle while fire is high
// and produces up to two token records for the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_scan import ast_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] ch,
	input  wire logic       eoi,
	output push_t           push
);

	localparam int LX = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
	localparam int CX = (COLUMN_BITS > COLUMN_W) ? COLUMN_BITS : COLUMN_W;
	localparam int OX = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;

	scan_mode_t             mode_q, mode_d;
	logic                   cr_q, cr_d;
	logic [LINE_BITS-1:0]   line_q, line_d, sline_q, sline_d;
	logic [COLUMN_BITS-1:0] col_q, col_d, scol_q, scol_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, soff_q, soff_d;
	logic [LENGTH_W-1:0]    wlen_q, wlen_d;
	logic [7:0]             wfirst_q, wfirst_d;

	logic                   is_digit, is_letter, is_nl, is_end, is_blank;
	logic                   in_word, cont, absorb, skip_cmt, grow, flush, has_fresh;
	logic [OFFSET_BITS-1:0] off_inc;
	logic [COLUMN_BITS-1:0] col_inc;
	logic [LINE_BITS-1:0]   line_inc;
	logic [LX-1:0]          line_x, sline_x;
	logic [CX-1:0]          col_x, scol_x;
	logic [OX-1:0]          off_x, soff_x;
	token_t                 word_tok, fresh_tok;
	logic [3:0]             fresh_kind;

	assign is_digit  = (ch >= "0") && (ch <= "9");
	assign is_letter = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
	assign is_nl     = (ch == CH_LF) || (ch == CH_CR);
	assign is_end    = eoi || (ch == CH_NUL);
	assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB);

	assign in_word  = (mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT);
	assign cont     = is_digit || is_letter ||
	                  ((mode_q == MODE_IDENT) && ((ch == CH_UNDER) || (ch == CH_DOT)));
	assign absorb   = !is_end && cr_q && (ch == CH_LF);
	assign skip_cmt = !is_end && !absorb && (mode_q == MODE_COMMENT) && !is_nl;
	assign grow     = !is_end && !absorb && in_word && cont;
	assign flush    = in_word && (is_end || (!absorb && !cont));

	// a byte handled from idle makes a token unless it is blank, ';', a word start or an LF right after CR
	assign has_fresh = !absorb && !skip_cmt && !grow &&
	                   (is_end || !(is_blank || (ch == CH_SEMI) || is_digit ||
	                                is_letter || (ch == CH_UNDER)));

	assign off_inc  = off_q + OFFSET_BITS'(1);
	assign col_inc  = (col_q == '1) ? col_q : col_q + COLUMN_BITS'(1);
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);

	assign line_x  = LX'(line_q);
	assign sline_x = LX'(sline_q);
	assign col_x   = CX'(col_q);
	assign scol_x  = CX'(scol_q);
	assign off_x   = OX'(off_q);
	assign soff_x  = OX'(soff_q);

	always_comb begin
		case (ch)
			CH_COMMA:  fresh_kind = K_COMMA;
			CH_COLON:  fresh_kind = K_COLON;
			CH_LBRACK: fresh_kind = K_LBRACKET;
			CH_RBRACK: fresh_kind = K_RBRACKET;
			CH_PLUS:   fresh_kind = K_PLUS;
			CH_MINUS:  fresh_kind = K_MINUS;
			CH_LF:     fresh_kind = K_NEWLINE;
			CH_CR:     fresh_kind = K_NEWLINE;
			default:   fresh_kind = K_UNKNOWN;
		endcase
		if (is_end)
			fresh_kind = K_EOF;
	end

	always_comb begin
		word_tok.kind   = (mode_q == MODE_NUMBER) ? K_NUMBER : K_IDENT;
		word_tok.line   = sline_x[LINE_W-1:0];
		word_tok.column = scol_x[COLUMN_W-1:0];
		word_tok.offset = soff_x[OFFSET_W-1:0];
		word_tok.length = wlen_q;
		word_tok.first  = wfirst_q;
		word_tok.last   = !has_fresh;

		fresh_tok.kind   = fresh_kind;
		fresh_tok.line   = line_x[LINE_W-1:0];
		fresh_tok.column = col_x[COLUMN_W-1:0];
		fresh_tok.offset = off_x[OFFSET_W-1:0];
		fresh_tok.length = is_end ? '0 : LENGTH_W'(1);
		fresh_tok.first  = is_end ? CH_NUL : (is_nl ? CH_LF : ch);
		fresh_tok.last   = 1'b1;

		push.tok0 = flush ? word_tok : fresh_tok;
		push.tok1 = fresh_tok;
		push.cnt  = fire ? (2'(flush) + 2'(has_fresh)) : 2'd0;
	end

	always_comb begin
		mode_d   = mode_q;
		cr_d     = 1'b0;
		line_d   = line_q;
		col_d    = col_q;
		off_d    = off_q;
		sline_d  = sline_q;
		scol_d   = scol_q;
		soff_d   = soff_q;
		wlen_d   = wlen_q;
		wfirst_d = wfirst_q;
		if (is_end) begin
			mode_d   = MODE_IDLE;
			line_d   = LINE_BITS'(1);
			col_d    = COLUMN_BITS'(1);
			off_d    = '0;
			sline_d  = LINE_BITS'(1);
			scol_d   = COLUMN_BITS'(1);
			soff_d   = '0;
			wlen_d   = '0;
			wfirst_d = '0;
		end else if (absorb) begin
			off_d = off_inc;
		end else if (skip_cmt) begin
			off_d = off_inc;
			col_d = col_inc;
		end else if (grow) begin
			if (wlen_q != '1)
				wlen_d = wlen_q + LENGTH_W'(1);
			off_d = off_inc;
			col_d = col_inc;
		end else begin
			mode_d = MODE_IDLE;
			if (is_nl) begin
				off_d  = off_inc;
				line_d = line_inc;
				col_d  = COLUMN_BITS'(1);
				cr_d   = (ch == CH_CR);
			end else begin
				off_d = off_inc;
				col_d = col_inc;
				if (ch == CH_SEMI) begin
					mode_d = MODE_COMMENT;
				end else if (is_digit || is_letter || (ch == CH_UNDER)) begin
					mode_d   = is_digit ? MODE_NUMBER : MODE_IDENT;
					sline_d  = line_q;
					scol_d   = col_q;
					soff_d   = off_q;
					wlen_d   = LENGTH_W'(1);
					wfirst_d = ch;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			cr_q     <= 1'b0;
			line_q   <= LINE_BITS'(1);
			col_q    <= COLUMN_BITS'(1);
			off_q    <= '0;
			sline_q  <= LINE_BITS'(1);
			scol_q   <= COLUMN_BITS'(1);
			soff_q   <= '0;
			wlen_q   <= '0;
			wfirst_q <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			cr_q     <= cr_d;
			line_q   <= line_d;
			col_q    <= col_d;
			off_q    <= off_d;
			sline_q  <= sline_d;
			scol_q   <= scol_d;
			soff_q   <= soff_d;
			wlen_q   <= wlen_d;
			wfirst_q <= wfirst_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ast_outq.sv
// ----------------------------------------------------------------------------
// Tokenizer output queue
// Small token queue: takes up to two tokens per cycle, hands out one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_outq import ast_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output token_t     head,
	output logic       head_valid,
	output logic       room
);

	token_t                 mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]  wptr_q, rptr_q;
	logic [OUTQ_CNT_W-1:0]  count_q;
	logic [OUTQ_PTR_W-1:0]  wptr_nx;

	assign wptr_nx    = wptr_q + OUTQ_PTR_W'(1);
	assign head       = mem_q[rptr_q];
	assign head_valid = (count_q != '0);
	// leave space for the two tokens one byte can cause
	assign room       = (count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wptr_q] <= push.tok0;
		if (push.cnt == 2'd2)
			mem_q[wptr_nx] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + OUTQ_PTR_W'(push.cnt);
			rptr_q  <= rptr_q + OUTQ_PTR_W'(pop);
			count_q <= count_q + OUTQ_CNT_W'(push.cnt) - OUTQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/assembly_source_tokenizer.sv
// ----------------------------------------------------------------------------
// Assembly source tokenizer
// Cuts a stream of source bytes into token descriptors.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one source byte per transaction in s_axis_tdata;
// s_axis_tlast marks end of source. A zero byte or tlast emits any pending
// word and an end-of-file token, then the position counters restart.
// Output channel (m_axis): one token per transaction; tuser is the kind,
// tdata carries position, length and first byte, tlast flags the final
// token caused by one source byte.
// Throughput: one byte per cycle while the queue has room; each byte yields zero, one or two tokens,
// so a run of bytes that each end a word and open a token is limited by the
// single output port to one token per cycle.
// With an empty queue, a byte's first token shows on m_axis once the queue
// has stored it, as the queue head drives m_axis with no further register.
// The input register feeds the scanner, whose tokens enter a four-entry
// queue; a byte is processed only while two queue slots are free.
// Reset clears the scanner state (line 1, column 1, offset 0) and empties
// the queue. When the receiver stalls, tokens wait in the queue and the
// input side keeps going until fewer than two slots are free, then tready
// drops.
// ----------------------------------------------------------------------------
`default_nettype none

module assembly_source_tokenizer import ast_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  wire logic        s_axis_tlast,  // end_of_input
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,  // [15:0] token_line, [31:16] token_column,
	                                        // [63:32] token_offset, [79:64] token_length,
	                                        // [87:80] first_char
	output logic [3:0]       m_axis_tuser,  // [3:0] token_kind
	output logic             m_axis_tlast   // last_of_run
);

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       eoi_s1;
	logic       fire, room, pop;
	push_t      push;
	token_t     head;

	assign fire          = vld_s1 && room;
	assign s_axis_tready = !vld_s1 || fire;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1  <= s_axis_tdata;
			eoi_s1 <= s_axis_tlast;
		end
	end

	ast_scan #(
		.LINE_BITS  (LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.ch    (ch_s1),
		.eoi   (eoi_s1),
		.push  (push)
	);

	ast_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.head_valid(m_axis_tvalid),
		.room      (room)
	);

	assign m_axis_tdata = {head.first, head.length, head.offset, head.column, head.line};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
